// ===== rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token kinds, lexer modes and character helpers for the
// source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int KIND_W     = 5;
  localparam int OUT_POS_W  = 16;
  localparam int OUT_VAL_W  = 31;
  localparam int OUT_NAME_W = 64;
  localparam int OUT_LEN_W  = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } lex_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]     token_kind;
    logic [OUT_POS_W-1:0]  token_row;
    logic [OUT_POS_W-1:0]  token_col;
    logic [OUT_VAL_W-1:0]  number_value;
    logic [OUT_NAME_W-1:0] name_packed;
    logic [OUT_LEN_W-1:0]  name_length;
    logic                  name_truncated;
    logic                  last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } lex_push_t;

  typedef enum logic [KIND_W-1:0] {
    K_INVALID = 5'd0,  K_IDENT  = 5'd1,  K_NUMBER = 5'd2,  K_IF     = 5'd3,
    K_ELSE    = 5'd4,  K_INT    = 5'd5,  K_ASSIGN = 5'd6,  K_EQEQ   = 5'd7,
    K_GT      = 5'd8,  K_GE     = 5'd9,  K_LT     = 5'd10, K_LE     = 5'd11,
    K_NE      = 5'd12, K_LPAREN = 5'd13, K_RPAREN = 5'd14, K_LBRACE = 5'd15,
    K_RBRACE  = 5'd16, K_SEMI   = 5'd17, K_PLUS   = 5'd18, K_MINUS  = 5'd19,
    K_EOF     = 5'd20
  } token_kind_t;

  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_COMMENT = 9'b000000010,
    M_SLASH   = 9'b000000100,
    M_IDENT   = 9'b000001000,
    M_NUMBER  = 9'b000010000,
    M_EQ      = 9'b000100000,
    M_GT      = 9'b001000000,
    M_LT      = 9'b010000000,
    M_BANG    = 9'b100000000
  } lex_mode_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;

  localparam logic [OUT_NAME_W-1:0] KW_IF   = 64'h6669;
  localparam logic [OUT_NAME_W-1:0] KW_ELSE = 64'h65736C65;
  localparam logic [OUT_NAME_W-1:0] KW_INT  = 64'h746E69;

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  function automatic token_kind_t single_kind(input logic [7:0] ch);
    token_kind_t k;
    case (ch)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h3B:   k = K_SEMI;
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  function automatic token_t make_token(input token_kind_t kind,
                                        input logic [OUT_POS_W-1:0] row,
                                        input logic [OUT_POS_W-1:0] col);
    token_t t;
    t = '0;
    t.token_kind = kind;
    t.token_row  = row;
    t.token_col  = col;
    return t;
  endfunction

endpackage

// ===== rtl/stl_result_fifo.sv =====
// ----------------------------------------------------------------------------
// stl_result_fifo
// Four-entry token queue; takes up to two tokens per cycle, pops one on ready.
// ----------------------------------------------------------------------------
module stl_result_fifo
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lex_push_t push,
  output logic      room,
  output logic      token_valid,
  input  logic      token_ready,
  output token_t    token_data
);

  token_t     slots [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] count;
  logic       pop;

  assign pop         = token_valid && token_ready;
  assign room        = count <= 3'd2;
  assign token_valid = count != 3'd0;
  assign token_data  = slots[head];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[tail + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + {1'b0, pop};
      tail  <= tail + push.count;
      count <= count + {1'b0, push.count} - {2'b0, pop};
    end
  end

endmodule

// ===== rtl/stl_core.sv =====
// ----------------------------------------------------------------------------
// stl_core
// Input register and single-pass lexer step: position tracking, pending
// token state and up to two tokens per character.
// ----------------------------------------------------------------------------
module stl_core
  import stl_pkg::*;
#(
  parameter int NAME_CHARS    = 8,
  parameter int POSITION_BITS = 16,
  parameter int VALUE_BITS    = 31
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_ready,
  input  lex_in_t   char_data,
  input  logic      room,
  output lex_push_t push
);

  localparam int PW = POSITION_BITS;
  localparam int VB = VALUE_BITS;
  localparam int NC = NAME_CHARS;
  localparam int CW = $clog2(NC + 1);
  localparam int BW = 8 * NC;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  logic          in_vld;
  lex_in_t       in_r;
  logic          step;

  lex_mode_t     mode, mode_next;
  logic [PW-1:0] cur_row, row_next;
  logic [PW-1:0] cur_col, col_next;
  logic [PW-1:0] tok_start, scol_next;
  logic [BW-1:0] name_buf, buf_next, buf_add;
  logic [CW-1:0] name_cnt, cnt_next, cnt_add;
  logic          ovf, ovf_next, ovf_add;
  logic [VB-1:0] acc, acc_next, acc_add;
  logic [VB+3:0] acc_prod;

  logic [7:0]    ch;
  logic [PW-1:0] row_inc, col_inc;
  logic [31:0]   row_ext, scol_ext, col_ext;
  logic [63:0]   val_ext;
  logic [15:0]   row16, scol16, col16;
  logic [3:0]    cnt4;
  token_kind_t   id_kind;
  token_t        id_tok, pend_tok, own_tok, cmp_tok;
  logic          pend_valid, own_valid, cont;
  lex_mode_t     own_mode;
  lex_push_t     res;

  assign step       = in_vld && room;
  assign char_ready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (char_ready) begin
      in_vld <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      in_r <= char_data;
    end
  end

  assign ch       = in_r.char_code;
  assign row_inc  = (cur_row == POS_MAX) ? cur_row : cur_row + PW'(1);
  assign col_inc  = (cur_col == POS_MAX) ? cur_col : cur_col + PW'(1);
  assign row_ext  = 32'(cur_row);
  assign col_ext  = 32'(cur_col);
  assign scol_ext = 32'(tok_start);
  assign val_ext  = 64'(acc);
  assign row16    = row_ext[15:0];
  assign col16    = col_ext[15:0];
  assign scol16   = scol_ext[15:0];
  assign cnt4     = 4'(name_cnt);

  // name byte append
  always_comb begin
    buf_add = name_buf;
    cnt_add = name_cnt;
    ovf_add = ovf;
    if (name_cnt == CW'(NC)) begin
      ovf_add = 1'b1;
    end else begin
      cnt_add = name_cnt + CW'(1);
      for (int i = 0; i < NC; i++) begin
        if (name_cnt == CW'(i)) begin
          buf_add[8*i +: 8] = ch;
        end
      end
    end
  end

  // times-ten accumulate, saturating
  assign acc_prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VB+4)'(ch[3:0]);
  assign acc_add  = (acc_prod[VB+3:VB] != 4'd0) ? {VB{1'b1}} : acc_prod[VB-1:0];

  always_comb begin
    id_kind = K_IDENT;
    if (!ovf) begin
      if (cnt4 == 4'd2 && 64'(name_buf) == KW_IF) begin
        id_kind = K_IF;
      end else if (cnt4 == 4'd4 && 64'(name_buf) == KW_ELSE) begin
        id_kind = K_ELSE;
      end else if (cnt4 == 4'd3 && 64'(name_buf) == KW_INT) begin
        id_kind = K_INT;
      end
    end
    id_tok = make_token(id_kind, row16, scol16);
    if (id_kind == K_IDENT) begin
      id_tok.name_packed    = 64'(name_buf);
      id_tok.name_length    = cnt4;
      id_tok.name_truncated = ovf;
    end
  end

  // token left pending by the current mode
  always_comb begin
    pend_valid = 1'b1;
    pend_tok   = make_token(K_INVALID, row16, scol16);
    case (mode)
      M_SLASH: begin
        pend_tok.name_packed = 64'(CH_SLASH);
        pend_tok.name_length = 4'd1;
      end
      M_BANG: begin
        pend_tok.name_packed = 64'(CH_BANG);
        pend_tok.name_length = 4'd1;
      end
      M_IDENT: pend_tok = id_tok;
      M_NUMBER: begin
        pend_tok = make_token(K_NUMBER, row16, scol16);
        pend_tok.number_value = val_ext[30:0];
      end
      M_EQ:    pend_tok = make_token(K_ASSIGN, row16, scol16);
      M_GT:    pend_tok = make_token(K_GT, row16, scol16);
      M_LT:    pend_tok = make_token(K_LT, row16, scol16);
      default: pend_valid = 1'b0;
    endcase
  end

  // two-character operators
  always_comb begin
    case (mode)
      M_EQ:    cmp_tok = make_token(K_EQEQ, row16, scol16);
      M_GT:    cmp_tok = make_token(K_GE, row16, scol16);
      M_LT:    cmp_tok = make_token(K_LE, row16, scol16);
      default: cmp_tok = make_token(K_NE, row16, scol16);
    endcase
  end

  // token or mode opened by this character
  always_comb begin
    own_valid = 1'b0;
    own_mode  = M_IDLE;
    own_tok   = make_token(single_kind(ch), row16, col16);
    if (ch == CH_NL || is_space(ch)) begin
      own_mode = M_IDLE;
    end else if (is_letter(ch)) begin
      own_mode = M_IDENT;
    end else if (is_digit(ch)) begin
      own_mode = M_NUMBER;
    end else if (ch == CH_SLASH) begin
      own_mode = M_SLASH;
    end else if (ch == CH_EQ) begin
      own_mode = M_EQ;
    end else if (ch == CH_GT) begin
      own_mode = M_GT;
    end else if (ch == CH_LT) begin
      own_mode = M_LT;
    end else if (ch == CH_BANG) begin
      own_mode = M_BANG;
    end else begin
      own_valid = 1'b1;
      if (single_kind(ch) == K_INVALID) begin
        own_tok.name_packed = 64'(ch);
        own_tok.name_length = 4'd1;
      end
    end
  end

  always_comb begin
    mode_next = mode;
    row_next  = cur_row;
    col_next  = col_inc;
    scol_next = tok_start;
    buf_next  = name_buf;
    cnt_next  = name_cnt;
    ovf_next  = ovf;
    acc_next  = acc;
    res       = '0;
    cont      = 1'b0;

    if (in_r.end_of_input) begin
      mode_next = M_IDLE;
      row_next  = PW'(1);
      col_next  = PW'(1);
      scol_next = PW'(1);
      buf_next  = '0;
      cnt_next  = '0;
      ovf_next  = 1'b0;
      acc_next  = '0;
      if (pend_valid) begin
        res.count  = 2'd2;
        res.first  = pend_tok;
        res.second = make_token(K_EOF, row16, col16);
      end else begin
        res.count = 2'd1;
        res.first = make_token(K_EOF, row16, col16);
      end
    end else begin
      case (mode)
        M_COMMENT: begin
          cont = 1'b1;
          if (ch == CH_NL) begin
            row_next  = row_inc;
            col_next  = PW'(1);
            mode_next = M_IDLE;
          end
        end
        M_SLASH: begin
          if (ch == CH_SLASH) begin
            cont      = 1'b1;
            mode_next = M_COMMENT;
          end
        end
        M_IDENT: begin
          if (is_letter(ch) || is_digit(ch)) begin
            cont     = 1'b1;
            buf_next = buf_add;
            cnt_next = cnt_add;
            ovf_next = ovf_add;
          end
        end
        M_NUMBER: begin
          if (is_digit(ch)) begin
            cont     = 1'b1;
            acc_next = acc_add;
          end
        end
        M_EQ, M_GT, M_LT, M_BANG: begin
          if (ch == CH_EQ) begin
            cont      = 1'b1;
            mode_next = M_IDLE;
            res.count = 2'd1;
            res.first = cmp_tok;
          end
        end
        default: cont = 1'b0;
      endcase

      if (!cont) begin
        mode_next = own_mode;
        scol_next = cur_col;
        buf_next  = '0;
        cnt_next  = '0;
        ovf_next  = 1'b0;
        acc_next  = '0;
        if (ch == CH_NL) begin
          row_next = row_inc;
          col_next = PW'(1);
        end else if (is_letter(ch)) begin
          buf_next[7:0] = ch;
          cnt_next      = CW'(1);
        end else if (is_digit(ch)) begin
          acc_next = VB'(ch[3:0]);
        end
        if (pend_valid && own_valid) begin
          res.count  = 2'd2;
          res.first  = pend_tok;
          res.second = own_tok;
        end else if (pend_valid) begin
          res.count = 2'd1;
          res.first = pend_tok;
        end else if (own_valid) begin
          res.count = 2'd1;
          res.first = own_tok;
        end
      end
    end

    if (res.count == 2'd2) begin
      res.second.last_of_run = 1'b1;
    end else begin
      res.first.last_of_run = 1'b1;
    end
    if (!step) begin
      res.count = 2'd0;
    end
  end

  assign push = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      cur_row   <= PW'(1);
      cur_col   <= PW'(1);
      tok_start <= PW'(1);
      name_buf  <= '0;
      name_cnt  <= '0;
      ovf       <= 1'b0;
      acc       <= '0;
    end else if (step) begin
      mode      <= mode_next;
      cur_row   <= row_next;
      cur_col   <= col_next;
      tok_start <= scol_next;
      name_buf  <= buf_next;
      name_cnt  <= cnt_next;
      ovf       <= ovf_next;
      acc       <= acc_next;
    end
  end

endmodule

// ===== rtl/source_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// source_token_lexer_unit
// Streaming lexer: one ASCII character (or end mark) per transfer in, tokens
// with kind, position, number value and name bytes out.
// ----------------------------------------------------------------------------
// Accepts one character per cycle while the queue has room. Each character
// is held in an input register and lexed combinationally, producing zero,
// one or two tokens that go into a four-entry token queue whose registered
// slots drive the output. The output side moves one token per cycle while
// token_ready is high, so characters that end a pending token and also form
// one of their own (e.g. "a+") leave two tokens in turn; input stalls only
// when the queue holds three or more tokens. last_of_run marks the final
// token of each character, and an end mark always yields an eof token and
// resets row, column and all pending token state.
module source_token_lexer_unit
  import stl_pkg::*;
#(
  parameter int NAME_CHARS    = 8,
  parameter int POSITION_BITS = 16,
  parameter int VALUE_BITS    = 31
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    char_valid,
  output logic    char_ready,
  input  lex_in_t char_data,
  output logic    token_valid,
  input  logic    token_ready,
  output token_t  token_data
);

  lex_push_t push;
  logic      room;

  stl_core #(
    .NAME_CHARS    (NAME_CHARS),
    .POSITION_BITS (POSITION_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .room       (room),
    .push       (push)
  );

  stl_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data)
  );

endmodule

// ===== rtl/stl_checker.sv =====
// ----------------------------------------------------------------------------
// stl_checker
// Port-level checks on the token output of the lexer.
// ----------------------------------------------------------------------------
module stl_checker
  import stl_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   token_valid,
  input logic   token_ready,
  input token_t token_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !token_valid)
    else $error("token output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token_data))
    else $error("stalled token transfer changed");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_data.token_kind == K_EOF |-> token_data.last_of_run)
    else $error("eof token without last_of_run");

  a_value_only_number: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_data.token_kind != K_NUMBER |-> token_data.number_value == '0)
    else $error("non-number token carries a value");

endmodule

bind source_token_lexer_unit stl_checker u_stl_checker (.*);
